// ===== hdl/cfc_pkg.sv =====
// Shared types and constants for the command frame checker.
`timescale 1ns / 1ps

package cfc_pkg;

    // Frame layout: byte positions within a command frame
    localparam int POS_MAGIC   = 0;
    localparam int POS_VERSION = 1;
    localparam int POS_TYPE    = 2;
    localparam int POS_SEQ     = 3;
    localparam int POS_TIME_LO = 4;
    localparam int POS_TIME_HI = 7;
    localparam int POS_CMD     = 9;
    localparam int POS_LEN     = 10;
    localparam int POS_PAYLOAD = 11;
    localparam int FRAME_BASE  = 12;

    // CRC-8, MSB first, no reflection, no final xor
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    // payload_count saturates at this value
    localparam logic [4:0] COUNT_SAT = 5'd31;

    // Result item kinds
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC    = 3'd0,
        CFG_VERSION  = 3'd1,
        CFG_CMD_TYPE = 3'd2,
        CFG_LOW_ID   = 3'd3,
        CFG_HIGH_ID  = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_INVALID     = 2'd1,
        ST_CRC_FAIL    = 2'd2,
        ST_UNSUPPORTED = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] magic_value;
        logic [7:0] version_value;
        logic [7:0] command_type_value;
        logic [7:0] lowest_command_id;
        logic [7:0] highest_command_id;
    } cfg_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } frame_in_t;

    typedef struct packed {
        logic        item_kind;
        status_t     status;
        logic [7:0]  frame_seq;
        logic [31:0] frame_time;
        logic [7:0]  cmd_code;
        logic [4:0]  payload_count;
        logic [7:0]  payload_byte;
        logic        last_result;
    } result_t;

    // Frame summary handed from the parser to the result sequencer
    typedef struct packed {
        status_t     status;
        logic [7:0]  seq;
        logic [31:0] stamp;
        logic [7:0]  cmd;
        logic [4:0]  count;
        logic [7:0]  length;
        logic        bank;
    } frame_sum_t;

endpackage

// ===== hdl/command_frame_checker.sv =====
// Top level of the command frame checker: config registers, parser, buffer, sequencer.
//
// Usage:
//   Frame channel (frame_valid / frame_stall / frame_data) takes one frame byte
//   per transaction; frame_end marks the last byte, which is the frame CRC.
//   Result channel (result_valid / result_stall / result_data) gives one summary
//   transaction per frame, followed by the payload bytes when the status is ok;
//   last_result flags the final transaction of a frame.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   magic, version, type and command id range registers; cfg_ready is always high.
// Timing:
//   Frame bytes are taken one per cycle while frame_stall is low. The summary
//   appears on the result channel the cycle after the frame's last byte is
//   taken, and payload bytes follow one per cycle while result_stall is low.
//   Payload goes into a two-bank buffer, so a frame can be received while the
//   previous one drains. A frame's last byte waits (frame_stall high) until the
//   previous frame's final result transaction is taken.
// Reset:
//   Frame state and the output register clear; registers go to magic 0,
//   version 0, type 0, id range 0 to 255. The buffer needs no clearing.
//   A stalled result transaction holds its fields until taken.
`timescale 1ns / 1ps

module command_frame_checker #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           frame_valid,
    output logic                           frame_stall,
    input  cfc_pkg::frame_in_t             frame_data,
    output logic                           result_valid,
    input  logic                           result_stall,
    output cfc_pkg::result_t               result_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data
);
    import cfc_pkg::*;

    localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int ADDR_W = IDX_W + 1;

    cfg_t              cfg_reg, cfg_next;
    frame_sum_t        sum;
    logic              frame_fire;
    logic              end_ready;
    logic              wr_bank;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MAGIC:    cfg_next.magic_value        = cfg_data;
                CFG_VERSION:  cfg_next.version_value      = cfg_data;
                CFG_CMD_TYPE: cfg_next.command_type_value = cfg_data;
                CFG_LOW_ID:   cfg_next.lowest_command_id  = cfg_data;
                CFG_HIGH_ID:  cfg_next.highest_command_id = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.magic_value        <= 8'd0;
            cfg_reg.version_value      <= 8'd0;
            cfg_reg.command_type_value <= 8'd0;
            cfg_reg.lowest_command_id  <= 8'd0;
            cfg_reg.highest_command_id <= 8'd255;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Frame handshake: only the last byte waits on the result side
    assign frame_stall = frame_data.frame_end && !end_ready;
    assign frame_fire  = frame_valid && !frame_stall;

    cfc_frame_parse #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_fire (frame_fire),
        .frame_data (frame_data),
        .cfg        (cfg_reg),
        .sum        (sum),
        .wr_bank    (wr_bank),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    cfc_payload_buf #(
        .ADDR_W (ADDR_W)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cfc_result_seq #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (frame_fire && frame_data.frame_end),
        .sum          (sum),
        .wr_bank      (wr_bank),
        .rd_data      (rd_data),
        .result_stall (result_stall),
        .end_ready    (end_ready),
        .rd_addr      (rd_addr),
        .result_valid (result_valid),
        .result_data  (result_data)
    );

endmodule

// ===== hdl/cfc_frame_parse.sv =====
// Byte-level frame parser: header checks, CRC, field capture, payload writes.
`timescale 1ns / 1ps

module cfc_frame_parse #(
    parameter int MAX_PAYLOAD = 16,
    parameter int ADDR_W      = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   frame_fire,
    input  cfc_pkg::frame_in_t     frame_data,
    input  cfc_pkg::cfg_t          cfg,
    output cfc_pkg::frame_sum_t    sum,
    output logic                   wr_bank,
    output logic                   wr_en,
    output logic [ADDR_W-1:0]      wr_addr,
    output logic [7:0]             wr_data
);
    import cfc_pkg::*;

    localparam int FRAME_MAX = FRAME_BASE + MAX_PAYLOAD;
    localparam int BC_W      = $clog2(FRAME_MAX + 1);
    localparam int TOT_W     = BC_W + 1;
    localparam int SUM_W     = (TOT_W > 8) ? TOT_W + 1 : 9;
    localparam int IDX_W     = ADDR_W - 1;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 8'h00) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    logic [7:0]      crc_reg, crc_next;
    logic [BC_W-1:0] count_reg, count_next;
    logic            header_bad_reg, header_bad_next;
    logic [7:0]      seq_reg, seq_next;
    logic [31:0]     time_reg, time_next;
    logic [7:0]      cmd_reg, cmd_next;
    logic [7:0]      length_reg, length_next;
    logic            bank_reg, bank_next;

    logic [7:0]       b;
    logic             in_range;
    logic [TOT_W-1:0] total;
    logic             frame_bad;
    logic             store_slot;

    assign b        = frame_data.rx_byte;
    assign in_range = count_reg < BC_W'(FRAME_MAX);
    assign total    = TOT_W'(count_reg) + TOT_W'(1);

    // Payload store write for bytes 11 up to FRAME_MAX - 2
    assign store_slot = in_range && (count_reg >= BC_W'(POS_PAYLOAD))
                        && (count_reg < BC_W'(FRAME_MAX - 1));
    assign wr_en   = frame_fire && !frame_data.frame_end && store_slot;
    assign wr_addr = {bank_reg, IDX_W'(count_reg - BC_W'(POS_PAYLOAD))};
    assign wr_data = b;
    assign wr_bank = bank_reg;

    // Frame state update
    always_comb
    begin
        crc_next        = crc_reg;
        count_next      = count_reg;
        header_bad_next = header_bad_reg;
        seq_next        = seq_reg;
        time_next       = time_reg;
        cmd_next        = cmd_reg;
        length_next     = length_reg;
        bank_next       = bank_reg;
        if (frame_fire) begin
            if (!frame_data.frame_end) begin
                if (in_range) begin
                    if (count_reg == BC_W'(POS_MAGIC) && b != cfg.magic_value) begin
                        header_bad_next = 1'b1;
                    end
                    if (count_reg == BC_W'(POS_VERSION) && b != cfg.version_value) begin
                        header_bad_next = 1'b1;
                    end
                    if (count_reg == BC_W'(POS_TYPE) && b != cfg.command_type_value) begin
                        header_bad_next = 1'b1;
                    end
                    if (count_reg == BC_W'(POS_SEQ)) begin
                        seq_next = b;
                    end
                    if (count_reg >= BC_W'(POS_TIME_LO) && count_reg <= BC_W'(POS_TIME_HI)) begin
                        time_next[{count_reg[1:0], 3'b000} +: 8] = b;
                    end
                    if (count_reg == BC_W'(POS_CMD)) begin
                        cmd_next = b;
                    end
                    if (count_reg == BC_W'(POS_LEN)) begin
                        length_next = b;
                    end
                    count_next = count_reg + BC_W'(1);
                end
                crc_next = crc8_step(crc_reg, b);
            end else begin
                // frame end: clear for the next frame, flip payload bank
                crc_next        = '0;
                count_next      = '0;
                header_bad_next = 1'b0;
                seq_next        = '0;
                time_next       = '0;
                cmd_next        = '0;
                length_next     = '0;
                bank_next       = ~bank_reg;
            end
        end
    end

    // Verdict for the frame whose last byte is on the input
    assign frame_bad = (total < TOT_W'(FRAME_BASE)) || (total > TOT_W'(FRAME_MAX))
                       || header_bad_reg || (length_reg > 8'(MAX_PAYLOAD))
                       || (SUM_W'(total) != (SUM_W'(FRAME_BASE) + SUM_W'(length_reg)));

    always_comb
    begin
        priority if (frame_bad) begin
            sum.status = ST_INVALID;
        end else if (b != crc_reg) begin
            sum.status = ST_CRC_FAIL;
        end else if (cmd_reg < cfg.lowest_command_id || cmd_reg > cfg.highest_command_id) begin
            sum.status = ST_UNSUPPORTED;
        end else begin
            sum.status = ST_OK;
        end
        sum.seq    = seq_reg;
        sum.stamp  = time_reg;
        sum.cmd    = cmd_reg;
        sum.count  = (length_reg > 8'(COUNT_SAT)) ? COUNT_SAT : length_reg[4:0];
        sum.length = length_reg;
        sum.bank   = bank_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg        <= '0;
            count_reg      <= '0;
            header_bad_reg <= 1'b0;
            seq_reg        <= '0;
            time_reg       <= '0;
            cmd_reg        <= '0;
            length_reg     <= '0;
            bank_reg       <= 1'b0;
        end else begin
            crc_reg        <= crc_next;
            count_reg      <= count_next;
            header_bad_reg <= header_bad_next;
            seq_reg        <= seq_next;
            time_reg       <= time_next;
            cmd_reg        <= cmd_next;
            length_reg     <= length_next;
            bank_reg       <= bank_next;
        end
    end

endmodule

// ===== hdl/cfc_payload_buf.sv =====
// Two-bank payload buffer: one write port, one registered read port.
`timescale 1ns / 1ps

module cfc_payload_buf #(
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);
    import cfc_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/cfc_result_seq.sv =====
// Result sequencer: output register, summary then payload bytes from the buffer.
`timescale 1ns / 1ps

module cfc_result_seq #(
    parameter int MAX_PAYLOAD = 16,
    parameter int ADDR_W      = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  cfc_pkg::frame_sum_t  sum,
    input  logic                 wr_bank,
    input  logic [7:0]           rd_data,
    input  logic                 result_stall,
    output logic                 end_ready,
    output logic [ADDR_W-1:0]    rd_addr,
    output logic                 result_valid,
    output cfc_pkg::result_t     result_data
);
    import cfc_pkg::*;

    localparam int IDX_W = ADDR_W - 1;
    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int CMP_W = CNT_W + 1;

    logic             out_valid_reg, out_valid_next;
    logic             out_kind_reg, out_kind_next;
    logic             out_last_reg, out_last_next;
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [CNT_W-1:0] out_plen_reg, out_plen_next;
    logic             rd_bank_reg, rd_bank_next;

    status_t          sum_status_reg;
    logic [7:0]       sum_seq_reg;
    logic [31:0]      sum_time_reg;
    logic [7:0]       sum_cmd_reg;
    logic [4:0]       sum_count_reg;

    logic             adv;
    logic             step;
    logic [IDX_W-1:0] idx_step;

    // Output slot frees when empty or taken; a new frame may load after the last item
    assign adv       = !out_valid_reg || !result_stall;
    assign end_ready = adv && (!out_valid_reg || out_last_reg);
    assign step      = adv && out_valid_reg && !out_last_reg;
    assign idx_step  = (out_kind_reg == KIND_PAYLOAD) ? (out_idx_reg + IDX_W'(1)) : '0;

    // Re-read the current entry while stalled so the read data holds
    assign rd_addr = step ? {rd_bank_reg, idx_step} : {rd_bank_reg, out_idx_reg};

    // Sequencer next state
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        out_idx_next   = out_idx_reg;
        out_plen_next  = out_plen_reg;
        rd_bank_next   = rd_bank_reg;
        priority if (load) begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_SUMMARY;
            out_last_next  = (sum.status != ST_OK) || (sum.length == 8'd0);
            out_idx_next   = '0;
            out_plen_next  = (sum.status == ST_OK) ? CNT_W'(sum.length) : '0;
            rd_bank_next   = sum.bank;
        end else if (step) begin
            out_kind_next = KIND_PAYLOAD;
            out_idx_next  = idx_step;
            out_last_next = (CMP_W'(idx_step) + CMP_W'(1)) == CMP_W'(out_plen_reg);
        end else if (adv) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_SUMMARY;
            out_last_reg  <= 1'b0;
            out_idx_reg   <= '0;
            out_plen_reg  <= '0;
            rd_bank_reg   <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_last_reg  <= out_last_next;
            out_idx_reg   <= out_idx_next;
            out_plen_reg  <= out_plen_next;
            rd_bank_reg   <= rd_bank_next;
        end
    end

    // Summary fields, captured at frame end
    always_ff @(posedge clk)
    begin
        if (load) begin
            sum_status_reg <= sum.status;
            sum_seq_reg    <= sum.seq;
            sum_time_reg   <= sum.stamp;
            sum_cmd_reg    <= sum.cmd;
            sum_count_reg  <= sum.count;
        end
    end

    // Result transaction: unused fields read as zero
    always_comb
    begin
        result_data.item_kind   = out_kind_reg;
        result_data.last_result = out_last_reg;
        if (out_kind_reg == KIND_PAYLOAD) begin
            result_data.status        = ST_OK;
            result_data.frame_seq     = '0;
            result_data.frame_time    = '0;
            result_data.cmd_code      = '0;
            result_data.payload_count = '0;
            result_data.payload_byte  = rd_data;
        end else begin
            result_data.status        = sum_status_reg;
            result_data.frame_seq     = sum_seq_reg;
            result_data.frame_time    = sum_time_reg;
            result_data.cmd_code      = sum_cmd_reg;
            result_data.payload_count = sum_count_reg;
            result_data.payload_byte  = '0;
        end
    end

    assign result_valid = out_valid_reg;

    // Payload index stays inside the frame's payload length
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_PAYLOAD)
        |-> (CMP_W'(out_idx_reg) < CMP_W'(out_plen_reg)))
        else $error("payload index beyond payload length");

    // Last flag on a payload byte marks exactly the final byte
    a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_PAYLOAD)
        |-> (out_last_reg == ((CMP_W'(out_idx_reg) + CMP_W'(1)) == CMP_W'(out_plen_reg))))
        else $error("last flag wrong on payload byte");

    // A failed frame ends at its summary
    a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_SUMMARY && sum_status_reg != ST_OK)
        |-> out_last_reg)
        else $error("failed frame summary not marked last");

    // The bank being drained is never the bank the parser writes
    a_bank_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_PAYLOAD) |-> (rd_bank_reg != wr_bank))
        else $error("payload drain bank collides with write bank");

endmodule

// ===== tb/sv/cfc_result_checker.sv =====
// Result checker for the command frame checker: predicts and compares result transactions.
`timescale 1ns / 1ps

module cfc_result_checker #(
    parameter int PAYLOAD_MAX = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          frame_valid,
    input  logic                          frame_stall,
    input  cfc_pkg::frame_in_t            frame_data,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  cfc_pkg::result_t              result_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [cfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    output int                            mismatch_count,
    output int                            pending_results
);
    import cfc_pkg::*;

    localparam int FRAME_LIMIT  = FRAME_BASE + PAYLOAD_MAX;
    localparam int REPORT_LIMIT = 10;

    // Local copy of the configuration registers
    logic [7:0] magic_q;
    logic [7:0] version_q;
    logic [7:0] type_q;
    logic [7:0] low_id_q;
    logic [7:0] high_id_q;

    // Frame parse state
    logic [7:0]  crc_acc;
    int          bytes_seen;
    logic        header_fault;
    logic [7:0]  seq_q;
    logic [31:0] stamp_q;
    logic [7:0]  cmd_q;
    logic [7:0]  length_q;
    logic [7:0]  payload_q [PAYLOAD_MAX];

    // Results predicted but not yet seen on the result channel
    result_t awaited_results [$];
    result_t want;

    initial
    begin
        mismatch_count  = 0;
        pending_results = 0;
    end

    // CRC-8, poly 0x07, MSB first
    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_TOP) != 8'h00)
                c = (c << 1) ^ CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

    function automatic string show(input result_t r);
        return $sformatf("kind=%0d status=%0d seq=%h time=%h cmd=%h count=%0d byte=%h last=%0d",
                         r.item_kind, r.status, r.frame_seq, r.frame_time, r.cmd_code,
                         r.payload_count, r.payload_byte, r.last_result);
    endfunction

    task automatic clear_frame();
        crc_acc      = 8'h00;
        bytes_seen   = 0;
        header_fault = 1'b0;
        seq_q        = 8'h00;
        stamp_q      = 32'h0;
        cmd_q        = 8'h00;
        length_q     = 8'h00;
    endtask

    // One non-final frame byte: header checks, field capture, payload buffering
    task automatic absorb_byte(input logic [7:0] b);
        int idx;
        idx = bytes_seen;
        if (idx < FRAME_LIMIT)
        begin
            if (idx == POS_MAGIC && b != magic_q)
                header_fault = 1'b1;
            if (idx == POS_VERSION && b != version_q)
                header_fault = 1'b1;
            if (idx == POS_TYPE && b != type_q)
                header_fault = 1'b1;
            if (idx == POS_SEQ)
                seq_q = b;
            if (idx >= POS_TIME_LO && idx <= POS_TIME_HI)
                stamp_q[(idx - POS_TIME_LO) * 8 +: 8] = b;
            if (idx == POS_CMD)
                cmd_q = b;
            if (idx == POS_LEN)
                length_q = b;
            if (idx >= POS_PAYLOAD && idx - POS_PAYLOAD < PAYLOAD_MAX)
                payload_q[idx - POS_PAYLOAD] = b;
            bytes_seen = idx + 1;
        end
        crc_acc = crc8_next(crc_acc, b);
    endtask

    // Frame end: summary, then payload bytes when the frame is good
    task automatic predict_frame_results(input logic [7:0] crc_byte);
        int      total;
        int      plen;
        status_t st;
        result_t r;
        total = bytes_seen + 1;
        plen  = length_q;
        if (total < FRAME_BASE || total > FRAME_LIMIT || header_fault ||
            plen > PAYLOAD_MAX || total != FRAME_BASE + plen)
            st = ST_INVALID;
        else if (crc_byte != crc_acc)
            st = ST_CRC_FAIL;
        else if (cmd_q < low_id_q || cmd_q > high_id_q)
            st = ST_UNSUPPORTED;
        else
            st = ST_OK;

        r               = '0;
        r.item_kind     = KIND_SUMMARY;
        r.status        = st;
        r.frame_seq     = seq_q;
        r.frame_time    = stamp_q;
        r.cmd_code      = cmd_q;
        r.payload_count = (length_q > COUNT_SAT) ? COUNT_SAT : length_q[4:0];
        r.last_result   = (st != ST_OK || plen == 0);
        awaited_results.push_back(r);

        if (st == ST_OK)
        begin
            for (int i = 0; i < plen && i < PAYLOAD_MAX; i++)
            begin
                r              = '0;
                r.item_kind    = KIND_PAYLOAD;
                r.payload_byte = payload_q[i];
                r.last_result  = (i + 1 == plen);
                awaited_results.push_back(r);
            end
        end
        clear_frame();
    endtask

    // Watch all three channels on the rising edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            magic_q   = 8'h00;
            version_q = 8'h00;
            type_q    = 8'h00;
            low_id_q  = 8'h00;
            high_id_q = 8'hFF;
            clear_frame();
            awaited_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAGIC:    magic_q   = cfg_data;
                    CFG_VERSION:  version_q = cfg_data;
                    CFG_CMD_TYPE: type_q    = cfg_data;
                    CFG_LOW_ID:   low_id_q  = cfg_data;
                    CFG_HIGH_ID:  high_id_q = cfg_data;
                    default:      ;
                endcase
            end

            if (frame_valid && !frame_stall)
            begin
                if (frame_data.frame_end)
                    predict_frame_results(frame_data.rx_byte);
                else
                    absorb_byte(frame_data.rx_byte);
            end

            if (result_valid && !result_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: unexpected result transaction: %s", $time,
                                 show(result_data));
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result_data !== want)
                    begin
                        if (mismatch_count < REPORT_LIMIT)
                        begin
                            $display("%0t: result differs, expected %s", $time, show(want));
                            $display("%0t:                  actual %s", $time,
                                     show(result_data));
                        end
                        mismatch_count++;
                    end
                end
            end
        end
        pending_results = awaited_results.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the command frame checker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import cfc_pkg::*;

    localparam int PAYLOAD_MAX  = 16;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_BYTES  = 1;
    localparam int DRAIN_CYCLES = 20;

    logic                 clk;
    logic                 rst_n;
    logic                 frame_valid;
    logic                 frame_stall;
    frame_in_t            frame_data;
    logic                 result_valid;
    logic                 result_stall;
    result_t              result_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    int mismatch_count;
    int pending_results;
    int cycle_count   = 0;
    int bytes_sent    = 0;
    bit no_idle       = 1'b0;

    // Register values as last written, used to build frames
    logic [7:0] cur_magic   = 8'h00;
    logic [7:0] cur_version = 8'h00;
    logic [7:0] cur_type    = 8'h00;
    logic [7:0] cur_low     = 8'h00;
    logic [7:0] cur_high    = 8'hFF;

    // Frame under construction, without its CRC byte
    logic [7:0] frame_buf [$];

    command_frame_checker #(
        .MAX_PAYLOAD (PAYLOAD_MAX)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame_data   (frame_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    cfc_result_checker #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .frame_valid     (frame_valid),
        .frame_stall     (frame_stall),
        .frame_data      (frame_data),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result_data     (result_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random stall before each transaction, none in burst frames
    initial
    begin : result_side
        int hold;
        result_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 19);
            repeat (hold)
            begin
                @(negedge clk);
                result_stall = 1'b1;
            end
            @(negedge clk);
            result_stall = 1'b0;
            do @(posedge clk); while (result_valid !== 1'b1);
        end
    end

    // Stimulus CRC, same polynomial as the frame format
    function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_TOP) != 8'h00)
                c = (c << 1) ^ CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] v);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        case (idx)
            CFG_MAGIC:    cur_magic   = v;
            CFG_VERSION:  cur_version = v;
            CFG_CMD_TYPE: cur_type    = v;
            CFG_LOW_ID:   cur_low     = v;
            CFG_HIGH_ID:  cur_high    = v;
            default:      ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] m, input logic [7:0] v, input logic [7:0] t,
                              input logic [7:0] lo, input logic [7:0] hi);
        write_reg(CFG_MAGIC, m);
        write_reg(CFG_VERSION, v);
        write_reg(CFG_CMD_TYPE, t);
        write_reg(CFG_LOW_ID, lo);
        write_reg(CFG_HIGH_ID, hi);
    endtask

    // Drop valid and wait until every predicted result is out and the block is quiet
    task automatic settle();
        @(negedge clk);
        frame_valid = 1'b0;
        repeat (2) @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // One frame byte transaction with a random gap ahead of it
    task automatic send_byte(input logic [7:0] b, input logic e);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap > 0)
        begin
            frame_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        frame_valid          = 1'b1;
        frame_data.rx_byte   = b;
        frame_data.frame_end = e;
        do @(posedge clk); while (frame_stall);
        bytes_sent++;
    endtask

    // Send frame_buf followed by its CRC byte, optionally corrupted
    task automatic transmit(input bit bad_crc);
        logic [7:0] crc;
        crc     = 8'h00;
        no_idle = ($urandom_range(0, 3) == 0);
        foreach (frame_buf[i])
        begin
            send_byte(frame_buf[i], 1'b0);
            crc = crc_step(crc, frame_buf[i]);
        end
        if (bad_crc)
            crc = crc ^ 8'($urandom_range(1, 255));
        send_byte(crc, 1'b1);
    endtask

    // Well-formed frame for the current registers
    task automatic compose(input int plen, input logic [7:0] cmd);
        frame_buf.delete();
        frame_buf.push_back(cur_magic);
        frame_buf.push_back(cur_version);
        frame_buf.push_back(cur_type);
        repeat (6) frame_buf.push_back(8'($urandom_range(0, 255)));
        frame_buf.push_back(cmd);
        frame_buf.push_back(8'(plen));
        repeat (plen) frame_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic random_frame();
        int pick;
        int plen;
        int n;
        plen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, PAYLOAD_MAX)
                                           : $urandom_range(0, 4);
        // mostly ids inside the configured range
        compose(plen, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(cur_high, cur_low)));
        pick = $urandom_range(0, 99);
        if (pick < 70)
            transmit(1'b0);
        else if (pick < 76)
            transmit(1'b1);
        else if (pick < 82)
        begin
            // corrupt one header byte
            n = $urandom_range(POS_TYPE, POS_MAGIC);
            frame_buf[n] = frame_buf[n] ^ 8'($urandom_range(1, 255));
            transmit(1'($urandom_range(0, 1)));
        end
        else if (pick < 87)
        begin
            frame_buf[POS_LEN] = 8'($urandom_range(0, 255));
            transmit(1'b0);
        end
        else if (pick < 92)
        begin
            // cut short
            n = $urandom_range(0, frame_buf.size() - 1);
            while (frame_buf.size() > n) void'(frame_buf.pop_back());
            transmit(1'($urandom_range(0, 1)));
        end
        else if (pick < 96)
        begin
            // run past the longest legal frame
            repeat ($urandom_range(1, 8) + FRAME_BASE + PAYLOAD_MAX - 1 - frame_buf.size())
                frame_buf.push_back(8'($urandom_range(0, 255)));
            transmit(1'b0);
        end
        else
        begin
            frame_buf.delete();
            repeat ($urandom_range(0, 30)) frame_buf.push_back(8'($urandom_range(0, 255)));
            transmit(1'($urandom_range(0, 1)));
        end
    endtask

    task automatic random_config(input int phase);
        logic [7:0] a;
        logic [7:0] b;
        a = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
        case (phase)
            0:       set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 8'h00, 8'hFF);
            1:       set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), (a < b) ? a : b, (a < b) ? b : a);
            2:       set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), a, a);
            default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), a, b);
        endcase
    endtask

    // Main sequence
    initial
    begin : stimulus
        int phase;
        int phase_start;
        rst_n       = 1'b0;
        frame_valid = 1'b0;
        frame_data  = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = 8'h00;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed frames
        set_config(8'hA5, 8'h01, 8'h10, 8'h20, 8'hE0);
        // lowest supported id, no payload
        compose(0, 8'h20);
        transmit(1'b0);
        // full payload at the highest supported id, field extremes
        compose(PAYLOAD_MAX, 8'hE0);
        frame_buf[POS_SEQ] = 8'hFF;
        for (int i = POS_TIME_LO; i <= POS_TIME_HI; i++)
            frame_buf[i] = 8'hFF;
        frame_buf[POS_PAYLOAD] = 8'h00;
        frame_buf[POS_PAYLOAD + PAYLOAD_MAX - 1] = 8'hFF;
        transmit(1'b0);
        // CRC failure outranks an unsupported id
        compose(0, 8'hFF);
        transmit(1'b1);
        // header fault together with a bad CRC
        compose(0, 8'h40);
        frame_buf[POS_VERSION] = 8'h02;
        transmit(1'b1);
        // short frame: lone end byte
        frame_buf.delete();
        transmit(1'b0);
        // overlong frame, one byte past the longest legal one
        compose(PAYLOAD_MAX, 8'h40);
        frame_buf.push_back(8'h33);
        transmit(1'b0);
        // payload length over the limit and over the count field
        compose(0, 8'h40);
        frame_buf[POS_LEN] = 8'hC8;
        transmit(1'b0);
        settle();

        // opposite header extremes and an empty id range
        set_config(8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F);
        compose(0, 8'h80);
        transmit(1'b0);
        settle();

        // Random frames under several register settings
        for (phase = 0; phase < 4; phase++)
        begin
            random_config(phase);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                random_frame();
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/cfc_pkg.sv
hdl/cfc_frame_parse.sv
hdl/cfc_payload_buf.sv
hdl/cfc_result_seq.sv
hdl/command_frame_checker.sv
tb/sv/cfc_result_checker.sv
tb/sv/tb.sv
